FILE: rtl/core/mbte_pkg.sv
// Package: constants, types and state encoding for the binomial table engine.
`timescale 1ns / 1ps
package mbte_pkg;
    localparam int TABLE_SIZE = 65536;
    localparam int ADDR_W = $clog2(TABLE_SIZE);
    localparam int VAL_W = 30;
    localparam logic [VAL_W-1:0] PRIME = 30'd1000000007;

    typedef enum logic [1:0] {
        MODE_BUILD = 2'd0,
        MODE_NPR   = 2'd1,
        MODE_NCR   = 2'd2,
        MODE_NHR   = 2'd3
    } t_mode;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FAC_MUL, S_FAC_WAIT,
        S_EXP_INIT, S_EXP_SQ, S_EXP_SQW, S_EXP_MUL, S_EXP_MULW,
        S_INV_MUL, S_INV_WAIT,
        S_Q_READ, S_Q_DATA, S_Q_MUL1, S_Q_MUL1W, S_Q_MUL2, S_Q_MUL2W,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] p;
    } t_mul_rsp;
endpackage

FILE: rtl/core/mbte_if.sv
// Interfaces: valid/ready channels for query items and results.
`timescale 1ns / 1ps
interface mbte_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic signed [17:0] n_value;
    logic signed [17:0] r_value;
    modport source (output valid, mode, n_value, r_value, input ready);
    modport sink   (input valid, mode, n_value, r_value, output ready);
endinterface

interface mbte_out_if;
    logic        valid;
    logic        ready;
    logic [29:0] value;
    logic        in_range;
    modport source (output valid, value, in_range, input ready);
    modport sink   (input valid, value, in_range, output ready);
endinterface

FILE: rtl/core/mbte_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module mbte_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/core/mbte_mulmod.sv
// Shift-add modular multiplier: one bit of b per cycle.
`timescale 1ns / 1ps
module mbte_mulmod (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbte_pkg::t_mul_req i_req,
    output mbte_pkg::t_mul_rsp o_rsp
);
    localparam int W = mbte_pkg::VAL_W;
    logic [W-1:0] r_a, r_acc, n_acc;
    logic [W-1:0] r_b;
    logic [$clog2(W+1)-1:0] r_cnt;
    logic r_busy, r_done;
    logic [W:0] dbl, add;

    always_comb begin
        dbl = {r_acc, 1'b0};
        if (dbl >= {1'b0, mbte_pkg::PRIME}) dbl = dbl - {1'b0, mbte_pkg::PRIME};
        add = dbl + {1'b0, r_a};
        if (r_b[W-1]) begin
            if (add >= {1'b0, mbte_pkg::PRIME}) add = add - {1'b0, mbte_pkg::PRIME};
            n_acc = add[W-1:0];
        end else begin
            n_acc = dbl[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_b   <= {r_b[W-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(W+1))'(W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;
endmodule

FILE: rtl/core/modular_binomial_table_engine_unit.sv
// Top level: factorial / inverse-factorial tables mod 1000000007 and nPr/nCr/nHr queries.
`timescale 1ns / 1ps
// One item at a time; ready is high only when idle. All arithmetic goes through a
// single bit-serial modular multiplier. A build item fills the factorial table
// upward (TABLE_SIZE-1 multiplies), inverts the top factorial by Fermat
// exponentiation (x^(p-2): 30 squarings and 15 multiplies), then fills the inverse
// table downward (TABLE_SIZE-1 multiplies). A query reads both tables in the same
// cycle (two single-port RAMs, registered read) and takes up to two multiplies;
// empty, out-of-range and nHr r==0 queries show their result the cycle after
// acceptance. Results wait in an output register until taken. Queries before the
// first build read undefined data.
module modular_binomial_table_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbte_in_if.sink     i_in,
    mbte_out_if.source  o_out
);
    localparam int AW = mbte_pkg::ADDR_W;
    localparam int W  = mbte_pkg::VAL_W;
    localparam logic [W-1:0] EXP = mbte_pkg::PRIME - 30'd2;

    mbte_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_idx;         // table walk index
    logic [W-1:0]  r_x;           // running value / base
    logic [W-1:0]  r_res;         // exponent accumulator / query partial product
    logic [W-1:0]  r_e;           // remaining exponent bits
    logic [$clog2(W+1)-1:0] r_ecnt;
    logic          r_inr, r_withr;
    logic [AW-1:0] r_n, r_nr, r_r;
    logic [W-1:0]  r_fn;
    logic [W-1:0]  r_value;

    mbte_pkg::t_mul_req mreq;
    mbte_pkg::t_mul_rsp mrsp;
    mbte_mulmod u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mreq), .o_rsp(mrsp));

    // table ports
    logic fac_we, inv_we;
    logic [AW-1:0] fac_addr, inv_addr;
    logic [W-1:0] fac_rd, inv_rd, inv_wd;
    mbte_ram #(.WIDTH(W), .DEPTH(mbte_pkg::TABLE_SIZE)) u_fac (
        .i_clk(i_clk), .i_we(fac_we), .i_addr(fac_addr), .i_wdata(r_x), .o_rdata(fac_rd));
    mbte_ram #(.WIDTH(W), .DEPTH(mbte_pkg::TABLE_SIZE)) u_inv (
        .i_clk(i_clk), .i_we(inv_we), .i_addr(inv_addr), .i_wdata(inv_wd), .o_rdata(inv_rd));

    // query decode (combinational, from the input channel)
    logic signed [19:0] qn, qr, qnr;
    logic q_empty, q_oor, q_one;
    always_comb begin
        qn = 20'(i_in.n_value);
        qr = 20'(i_in.r_value);
        q_one = 1'b0;
        if (mbte_pkg::t_mode'(i_in.mode) == mbte_pkg::MODE_NHR) begin
            q_one = (qr == 20'sd0);
            qn = qn + qr - 20'sd1;
        end
        qnr = qn - qr;
        q_empty = (qr < 20'sd0) || (qn < qr);
        q_oor = (qn >= 20'sd0) && (qn >= 20'(mbte_pkg::TABLE_SIZE));
    end

    wire in_fire  = i_in.valid && i_in.ready;
    wire out_fire = o_out.valid && o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mbte_pkg::S_IDLE:
                if (in_fire) begin
                    if (mbte_pkg::t_mode'(i_in.mode) == mbte_pkg::MODE_BUILD)
                        n_state = mbte_pkg::S_FAC_MUL;
                    else if (q_one || q_empty || q_oor) n_state = mbte_pkg::S_OUT;
                    else n_state = mbte_pkg::S_Q_READ;
                end
            mbte_pkg::S_FAC_MUL:  n_state = mbte_pkg::S_FAC_WAIT;
            mbte_pkg::S_FAC_WAIT:
                if (mrsp.done)
                    n_state = (r_idx == AW'(mbte_pkg::TABLE_SIZE - 2)) ?
                              mbte_pkg::S_EXP_INIT : mbte_pkg::S_FAC_MUL;
            mbte_pkg::S_EXP_INIT: n_state = mbte_pkg::S_EXP_SQ;
            mbte_pkg::S_EXP_SQ:   n_state = mbte_pkg::S_EXP_SQW;
            mbte_pkg::S_EXP_SQW:
                if (mrsp.done) n_state = r_e[W-1] ? mbte_pkg::S_EXP_MUL : mbte_pkg::S_EXP_MULW;
            mbte_pkg::S_EXP_MUL:  n_state = mbte_pkg::S_EXP_MULW;
            mbte_pkg::S_EXP_MULW:
                if (mrsp.done || !r_e[W-1])
                    n_state = (r_ecnt == ($clog2(W+1))'(W-1)) ?
                              mbte_pkg::S_INV_MUL : mbte_pkg::S_EXP_SQ;
            mbte_pkg::S_INV_MUL:  n_state = mbte_pkg::S_INV_WAIT;
            mbte_pkg::S_INV_WAIT:
                if (mrsp.done)
                    n_state = (r_idx == AW'(1)) ? mbte_pkg::S_OUT : mbte_pkg::S_INV_MUL;
            mbte_pkg::S_Q_READ:   n_state = mbte_pkg::S_Q_DATA;
            mbte_pkg::S_Q_DATA:   n_state = mbte_pkg::S_Q_MUL1;
            mbte_pkg::S_Q_MUL1:   n_state = mbte_pkg::S_Q_MUL1W;
            mbte_pkg::S_Q_MUL1W:
                if (mrsp.done) n_state = r_withr ? mbte_pkg::S_Q_MUL2 : mbte_pkg::S_OUT;
            mbte_pkg::S_Q_MUL2:   n_state = mbte_pkg::S_Q_MUL2W;
            mbte_pkg::S_Q_MUL2W:  if (mrsp.done) n_state = mbte_pkg::S_OUT;
            mbte_pkg::S_OUT:      if (out_fire) n_state = mbte_pkg::S_IDLE;
            default:              n_state = mbte_pkg::S_IDLE;
        endcase
    end

    // outputs / datapath controls
    always_comb begin
        mreq = '0;
        fac_we = 1'b0;
        inv_we = 1'b0;
        fac_addr = r_idx;
        inv_addr = r_idx;
        inv_wd = r_x;
        case (r_state)
            mbte_pkg::S_FAC_MUL: begin
                // r_x holds the factorial of r_idx
                fac_we = 1'b1;
                mreq.start = 1'b1; mreq.a = r_x; mreq.b = W'(r_idx) + 30'd1;
            end
            mbte_pkg::S_EXP_INIT: begin
                fac_we = 1'b1;  // top factorial
            end
            mbte_pkg::S_EXP_SQ: begin
                mreq.start = 1'b1; mreq.a = r_res; mreq.b = r_res;
            end
            mbte_pkg::S_EXP_MUL: begin
                mreq.start = 1'b1; mreq.a = r_res; mreq.b = r_x;
            end
            mbte_pkg::S_INV_MUL: begin
                mreq.start = 1'b1; mreq.a = r_x; mreq.b = W'(r_idx);
            end
            mbte_pkg::S_Q_READ: begin
                fac_addr = r_n; inv_addr = r_nr;
            end
            mbte_pkg::S_Q_MUL1: begin
                mreq.start = 1'b1; mreq.a = r_fn; mreq.b = r_res;
                inv_addr = r_r;
            end
            mbte_pkg::S_Q_MUL1W: begin
                inv_addr = r_r;  // keep inv[r] on the read port for the second multiply
            end
            mbte_pkg::S_Q_MUL2: begin
                mreq.start = 1'b1; mreq.a = r_res; mreq.b = inv_rd;
            end
            default: ;
        endcase
        if (r_state == mbte_pkg::S_INV_WAIT && mrsp.done) begin
            inv_we = 1'b1; inv_addr = r_idx - 1'b1; inv_wd = mrsp.p;
        end
        if (r_state == mbte_pkg::S_EXP_MULW &&
            (mrsp.done || !r_e[W-1]) && r_ecnt == ($clog2(W+1))'(W-1)) begin
            inv_we = 1'b1; inv_addr = AW'(mbte_pkg::TABLE_SIZE - 1);
            inv_wd = r_e[W-1] ? mrsp.p : r_res;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mbte_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state)
            mbte_pkg::S_IDLE:
                if (in_fire) begin
                    r_idx   <= '0;
                    r_x     <= 30'd1;
                    r_withr <= mbte_pkg::t_mode'(i_in.mode) != mbte_pkg::MODE_NPR;
                    r_n     <= qn[AW-1:0];
                    r_nr    <= qnr[AW-1:0];
                    r_r     <= qr[AW-1:0];
                    r_inr   <= (mbte_pkg::t_mode'(i_in.mode) == mbte_pkg::MODE_BUILD) ||
                               !(q_oor && !q_empty) || q_one;
                    r_value <= (q_one && mbte_pkg::t_mode'(i_in.mode) != mbte_pkg::MODE_BUILD)
                               ? 30'd1 : 30'd0;
                end
            mbte_pkg::S_FAC_WAIT:
                if (mrsp.done) begin
                    r_x <= mrsp.p; r_idx <= r_idx + 1'b1;
                end
            mbte_pkg::S_EXP_INIT: begin
                r_res <= 30'd1; r_e <= EXP; r_ecnt <= '0;
            end
            mbte_pkg::S_EXP_SQW:
                if (mrsp.done) r_res <= mrsp.p;
            mbte_pkg::S_EXP_MULW:
                if (mrsp.done || !r_e[W-1]) begin
                    if (r_e[W-1]) r_res <= mrsp.p;
                    r_e <= {r_e[W-2:0], 1'b0};
                    r_ecnt <= r_ecnt + 1'b1;
                    if (r_ecnt == ($clog2(W+1))'(W-1))
                        r_x <= r_e[W-1] ? mrsp.p : r_res;
                end
            mbte_pkg::S_INV_WAIT:
                if (mrsp.done) begin
                    r_x <= mrsp.p; r_idx <= r_idx - 1'b1;
                end
            mbte_pkg::S_Q_DATA: begin
                r_fn <= fac_rd; r_res <= inv_rd;
            end
            mbte_pkg::S_Q_MUL1W:
                if (mrsp.done) begin
                    r_res <= mrsp.p;
                    if (!r_withr) r_value <= mrsp.p;
                end
            mbte_pkg::S_Q_MUL2W:
                if (mrsp.done) r_value <= mrsp.p;
            default: ;
        endcase
    end

    assign i_in.ready     = (r_state == mbte_pkg::S_IDLE);
    assign o_out.valid    = (r_state == mbte_pkg::S_OUT);
    assign o_out.value    = r_value;
    assign o_out.in_range = r_inr;
endmodule
